@@ hw/rtl/assert_macros.svh @@
// Assertion helpers. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FDCI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define FDCI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/fdci_pkg.sv @@
package fdci_pkg;

	localparam int BYTE_W = 8;
	localparam int ADDR_W = 20;
	localparam int OP_W   = 2;
	localparam int CMD_W  = 4;
	localparam int PH_W   = 3;

	localparam int DEF_BUFFER_BYTES       = 128;
	localparam int DEF_SECTORS_PER_TRACK  = 26;
	localparam int DEF_MAX_TRACK          = 76;
	localparam int DEF_DRIVE_REGION_BYTES = 524288;

	// command codes, bits 3..1 of the command byte
	localparam logic [CMD_W-1:0] CMD_FILL   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_EMPTY  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 4'd4;
	localparam logic [CMD_W-1:0] CMD_STATUS = 4'd5;
	localparam logic [CMD_W-1:0] CMD_WRDEL  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_ERRREG = 4'd7;
	localparam logic [CMD_W-1:0] CMD_NONE   = 4'd15;

	localparam logic [PH_W-1:0] PH_IDLE   = 3'd0;
	localparam logic [PH_W-1:0] PH_SECTOR = 3'd1;
	localparam logic [PH_W-1:0] PH_TRACK  = 3'd2;
	localparam logic [PH_W-1:0] PH_FILL   = 3'd3;
	localparam logic [PH_W-1:0] PH_EMPTY  = 3'd4;

	localparam logic [OP_W-1:0] OP_NONE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

	localparam logic CFG_STATUS = 1'b0;
	localparam logic CFG_ERROR  = 1'b1;

	localparam logic [BYTE_W-1:0] INIT_BYTE    = 8'h84;
	localparam logic [BYTE_W-1:0] STATUS_RESET = 8'h84;
	localparam logic [BYTE_W-1:0] ERROR_RESET  = 8'h00;

	// partial result carried from the decode stage to the output stage
	typedef struct packed {
		logic              byte_valid;
		logic              from_ram;   // byte comes from the buffer read
		logic              ram_hit;    // entry has been written since reset
		logic [BYTE_W-1:0] byte_val;
		logic [OP_W-1:0]   op;
		logic              done;
		logic              err;
		logic              req;
		logic              outm;
	} s1_res_t;

endpackage

@@ hw/rtl/floppy_drive_command_interface.sv @@
// Drive side of a floppy controller command link. One transaction in (a run
// pulse carrying a shifted byte, or an init pulse) gives one transaction out
// with the shifted-out byte, any flash sector request and the four status
// levels. The block takes a transaction every cycle while the output does not
// stall. Decode and the sector buffer read are issued in the accepting cycle,
// into the stage register and the registered buffer RAM output; the flash
// address scaling is done in the output stage, so a result passes the stage
// register and then the output register. The output register decouples
// the two sides, so a stalled result does not block the next input while the
// second stage is free. The sector buffer reads as zero from reset until each
// byte is first filled (per-entry valid flags, no clearing pass). Status and
// error bytes are set through the write port: index 0 status, index 1 error
// register; write only while idle.
module floppy_drive_command_interface import fdci_pkg::*; #(
	parameter int BUFFER_BYTES       = DEF_BUFFER_BYTES,
	parameter int SECTORS_PER_TRACK  = DEF_SECTORS_PER_TRACK,
	parameter int MAX_TRACK          = DEF_MAX_TRACK,
	parameter int DRIVE_REGION_BYTES = DEF_DRIVE_REGION_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [BYTE_W-1:0] data_in,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              byte_valid,
	output logic [BYTE_W-1:0] byte_out,
	output logic [OP_W-1:0]   storage_op,
	output logic [ADDR_W-1:0] storage_address,
	output logic              done_level,
	output logic              error_level,
	output logic              request_level,
	output logic              output_mode
);

	localparam int AW    = $clog2(BUFFER_BYTES);
	localparam int LIN_W = $clog2((MAX_TRACK + 1) * SECTORS_PER_TRACK);

	logic              adv, valid_s1, drive_s1;
	s1_res_t           res_s1;
	logic [LIN_W-1:0]  lin_s1;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	fdci_ctrl #(
		.BUFFER_BYTES     (BUFFER_BYTES),
		.SECTORS_PER_TRACK(SECTORS_PER_TRACK),
		.MAX_TRACK        (MAX_TRACK)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.data_in  (data_in),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.res_s1   (res_s1),
		.lin_s1   (lin_s1),
		.drive_s1 (drive_s1),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	// a fill write always lands at an earlier edge than any empty read of it
	fdci_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(data_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fdci_out #(
		.BUFFER_BYTES      (BUFFER_BYTES),
		.SECTORS_PER_TRACK (SECTORS_PER_TRACK),
		.MAX_TRACK         (MAX_TRACK),
		.DRIVE_REGION_BYTES(DRIVE_REGION_BYTES)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.res_s1         (res_s1),
		.lin_s1         (lin_s1),
		.drive_s1       (drive_s1),
		.ram_rdata      (ram_rdata),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_valid     (byte_valid),
		.byte_out       (byte_out),
		.storage_op     (storage_op),
		.storage_address(storage_address),
		.done_level     (done_level),
		.error_level    (error_level),
		.request_level  (request_level),
		.output_mode    (output_mode)
	);

endmodule

@@ hw/rtl/fdci_ram.sv @@
module fdci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/fdci_ctrl.sv @@
module fdci_ctrl import fdci_pkg::*; #(
	parameter int BUFFER_BYTES      = DEF_BUFFER_BYTES,
	parameter int SECTORS_PER_TRACK = DEF_SECTORS_PER_TRACK,
	parameter int MAX_TRACK         = DEF_MAX_TRACK,
	localparam int AW    = $clog2(BUFFER_BYTES),
	localparam int LIN_W = $clog2((MAX_TRACK + 1) * SECTORS_PER_TRACK)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [BYTE_W-1:0] data_in,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              adv,
	output logic              valid_s1,
	output s1_res_t           res_s1,
	output logic [LIN_W-1:0]  lin_s1,
	output logic              drive_s1,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic              ram_re,
	output logic [AW-1:0]     ram_raddr
);

	localparam int IDX_W = $clog2(BUFFER_BYTES + 1);
	localparam int SEC_W = $clog2(SECTORS_PER_TRACK + 1);
	localparam logic [IDX_W-1:0]  IDX_END = IDX_W'(BUFFER_BYTES);
	localparam logic [BYTE_W-1:0] SEC_MAX = BYTE_W'(SECTORS_PER_TRACK);
	localparam logic [BYTE_W-1:0] TRK_MAX = BYTE_W'(MAX_TRACK);
	localparam logic [LIN_W-1:0]  SPT_L   = LIN_W'(SECTORS_PER_TRACK);

	logic [CMD_W-1:0]        cmd_q, cmd_n, cmd_e;
	logic [PH_W-1:0]         phase_q, phase_n, phase_e;
	logic                    drive_q, drive_n;
	logic [IDX_W-1:0]        idx_q, idx_n, idx_inc;
	logic [SEC_W-1:0]        sector_q, sector_n;
	logic                    done_q, done_n, err_q, err_n, req_q, req_n, outm_q, outm_n;
	logic [BYTE_W-1:0]       status_q, error_q;
	logic [BUFFER_BYTES-1:0] filled_q;
	logic                    in_fire, started, end_c;
	s1_res_t                 res_n;
	logic [LIN_W-1:0]        lin_n;

	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;
	assign idx_inc  = idx_q + 1'b1;

	always_comb begin
		cmd_n     = cmd_q;
		phase_n   = phase_q;
		drive_n   = drive_q;
		idx_n     = idx_q;
		sector_n  = sector_q;
		done_n    = done_q;
		err_n     = err_q;
		req_n     = req_q;
		outm_n    = outm_q;
		started   = 1'b0;
		end_c     = 1'b0;
		cmd_e     = cmd_q;
		phase_e   = phase_q;
		lin_n     = '0;
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_re    = 1'b0;
		ram_raddr = '0;
		res_n     = '0;
		if (action) begin
			res_n.byte_valid = 1'b1;
			res_n.byte_val   = INIT_BYTE;
			end_c            = 1'b1;
		end else begin
			started = (cmd_q == CMD_NONE);
			if (started) begin
				done_n  = 1'b0;
				err_n   = 1'b0;
				drive_n = data_in[4];
				cmd_e   = {1'b0, data_in[3:1]};
				phase_e = PH_IDLE;
			end
			cmd_n   = cmd_e;
			phase_n = phase_e;
			unique case (cmd_e)
				CMD_FILL: begin
					if (phase_e != PH_FILL) begin
						phase_n = PH_FILL;
						req_n   = 1'b1;
						idx_n   = '0;
					end else begin
						req_n  = 1'b0;
						ram_we = in_fire && (idx_q < IDX_END);
						idx_n  = idx_inc;
						if (idx_inc >= IDX_END) begin
							end_c = 1'b1;
						end else begin
							req_n = 1'b1;
						end
					end
				end
				CMD_EMPTY: begin
					if (phase_e != PH_EMPTY) begin
						phase_n          = PH_EMPTY;
						outm_n           = 1'b1;
						res_n.byte_valid = 1'b1;
						res_n.from_ram   = 1'b1;
						ram_re           = in_fire;
						ram_raddr        = '0;
						idx_n            = IDX_W'(1);
						req_n            = 1'b1;
					end else if (idx_q < IDX_END) begin
						res_n.byte_valid = 1'b1;
						res_n.from_ram   = 1'b1;
						ram_re           = in_fire;
						ram_raddr        = idx_q[AW-1:0];
						idx_n            = idx_inc;
						req_n            = 1'b1;
					end else begin
						req_n = 1'b0;
						end_c = 1'b1;
					end
				end
				CMD_WRITE, CMD_READ, CMD_WRDEL: begin
					if (phase_e != PH_SECTOR && phase_e != PH_TRACK) begin
						phase_n = PH_SECTOR;
						req_n   = 1'b1;
					end else if (phase_e == PH_SECTOR) begin
						req_n = 1'b0;
						if (data_in == '0 || data_in > SEC_MAX) begin
							err_n = 1'b1;
							end_c = 1'b1;
						end else begin
							sector_n = SEC_W'(data_in - 1'b1);
							phase_n  = PH_TRACK;
							req_n    = 1'b1;
						end
					end else begin
						req_n = 1'b0;
						end_c = 1'b1;
						if (data_in > TRK_MAX) begin
							err_n = 1'b1;
						end else begin
							// linear sector number; scaled to bytes in the output stage
							lin_n    = LIN_W'(data_in[6:0]) * SPT_L + LIN_W'(sector_q);
							res_n.op = (cmd_e == CMD_READ) ? OP_READ : OP_WRITE;
						end
					end
				end
				CMD_STATUS: begin
					res_n.byte_valid = 1'b1;
					res_n.byte_val   = status_q;
					end_c            = 1'b1;
				end
				CMD_ERRREG: begin
					res_n.byte_valid = 1'b1;
					res_n.byte_val   = error_q;
					end_c            = 1'b1;
				end
				default: begin
					end_c = 1'b1;
				end
			endcase
		end
		if (end_c) begin
			done_n  = 1'b1;
			outm_n  = 1'b0;
			cmd_n   = CMD_NONE;
			phase_n = PH_IDLE;
			idx_n   = '0;
		end
		res_n.ram_hit = filled_q[ram_raddr];
		res_n.done    = done_n;
		res_n.err     = err_n;
		res_n.req     = req_n;
		res_n.outm    = outm_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_NONE;
			phase_q  <= PH_IDLE;
			drive_q  <= 1'b0;
			idx_q    <= '0;
			sector_q <= '0;
			done_q   <= 1'b1;
			err_q    <= 1'b0;
			req_q    <= 1'b0;
			outm_q   <= 1'b0;
			filled_q <= '0;
			valid_s1 <= 1'b0;
			status_q <= STATUS_RESET;
			error_q  <= ERROR_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STATUS: status_q <= cfg_data;
					CFG_ERROR:  error_q  <= cfg_data;
					default:    status_q <= status_q;
				endcase
			end
			if (in_fire) begin
				cmd_q    <= cmd_n;
				phase_q  <= phase_n;
				drive_q  <= drive_n;
				idx_q    <= idx_n;
				sector_q <= sector_n;
				done_q   <= done_n;
				err_q    <= err_n;
				req_q    <= req_n;
				outm_q   <= outm_n;
				if (ram_we) begin
					filled_q[ram_waddr] <= 1'b1;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage payload, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1   <= res_n;
			lin_s1   <= lin_n;
			drive_s1 <= drive_n;
		end
	end

endmodule

@@ hw/rtl/fdci_out.sv @@
module fdci_out import fdci_pkg::*; #(
	parameter int BUFFER_BYTES       = DEF_BUFFER_BYTES,
	parameter int SECTORS_PER_TRACK  = DEF_SECTORS_PER_TRACK,
	parameter int MAX_TRACK          = DEF_MAX_TRACK,
	parameter int DRIVE_REGION_BYTES = DEF_DRIVE_REGION_BYTES,
	localparam int LIN_W = $clog2((MAX_TRACK + 1) * SECTORS_PER_TRACK)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  s1_res_t           res_s1,
	input  logic [LIN_W-1:0]  lin_s1,
	input  logic              drive_s1,
	input  logic [BYTE_W-1:0] ram_rdata,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              byte_valid,
	output logic [BYTE_W-1:0] byte_out,
	output logic [OP_W-1:0]   storage_op,
	output logic [ADDR_W-1:0] storage_address,
	output logic              done_level,
	output logic              error_level,
	output logic              request_level,
	output logic              output_mode
);

	// address arithmetic wraps at the 20-bit flash window
	localparam logic [ADDR_W-1:0] BB_A  = ADDR_W'(BUFFER_BYTES);
	localparam logic [ADDR_W-1:0] DRB_A = ADDR_W'(DRIVE_REGION_BYTES);

	logic [BYTE_W-1:0] byte_n;
	logic [ADDR_W-1:0] addr_n;

	assign adv = valid_s1 && (!out_valid || out_ready);

	always_comb begin
		if (res_s1.from_ram) begin
			byte_n = res_s1.ram_hit ? ram_rdata : '0;
		end else begin
			byte_n = res_s1.byte_val;
		end
		if (res_s1.op != OP_NONE) begin
			addr_n = ADDR_W'(lin_s1) * BB_A + (drive_s1 ? DRB_A : '0);
		end else begin
			addr_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_valid      <= res_s1.byte_valid;
			byte_out        <= byte_n;
			storage_op      <= res_s1.op;
			storage_address <= addr_n;
			done_level      <= res_s1.done;
			error_level     <= res_s1.err;
			request_level   <= res_s1.req;
			output_mode     <= res_s1.outm;
		end
	end

endmodule

@@ hw/rtl/fdci_checker.sv @@
`include "assert_macros.svh"

module fdci_checker import fdci_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              action,
	input logic [BYTE_W-1:0] data_in,
	input logic              cfg_we,
	input logic              cfg_index,
	input logic [BYTE_W-1:0] cfg_data,
	input logic              out_valid,
	input logic              out_ready,
	input logic              byte_valid,
	input logic [BYTE_W-1:0] byte_out,
	input logic [OP_W-1:0]   storage_op,
	input logic [ADDR_W-1:0] storage_address,
	input logic              done_level,
	input logic              error_level,
	input logic              request_level,
	input logic              output_mode
);

	// a stalled result transaction keeps its payload
	`FDCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(byte_out) && $stable(storage_address), "result changed while stalled")

	// a flash request ends a command cleanly and carries no byte
	`FDCI_ASSERT_NOW(a_req_clean, out_valid && storage_op != OP_NONE, done_level && !error_level && !request_level && !byte_valid && !output_mode, "bad levels with flash request")

	`FDCI_ASSERT_NOW(a_addr_zero, out_valid && storage_op == OP_NONE, storage_address == '0, "address without request")

	// output mode only while an empty command is in progress
	`FDCI_ASSERT_NOW(a_outm_busy, out_valid && output_mode, !done_level && byte_valid, "output mode with no byte or while done")

	`FDCI_ASSERT_NOW(a_op_legal, out_valid, storage_op == OP_NONE || storage_op == OP_READ || storage_op == OP_WRITE, "illegal storage op")

endmodule

bind floppy_drive_command_interface fdci_checker u_fdci_checker (.*);

@@ tb/sv/floppy_drive_command_interface_checker.sv @@
module floppy_drive_command_interface_checker import fdci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              action,
	input  logic [BYTE_W-1:0] data_in,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              byte_valid,
	input  logic [BYTE_W-1:0] byte_out,
	input  logic [OP_W-1:0]   storage_op,
	input  logic [ADDR_W-1:0] storage_address,
	input  logic              done_level,
	input  logic              error_level,
	input  logic              request_level,
	input  logic              output_mode,
	output int                mismatches,
	output int                outstanding
);

	localparam int BUF_BYTES  = DEF_BUFFER_BYTES;
	localparam int SPT        = DEF_SECTORS_PER_TRACK;
	localparam int LAST_TRACK = DEF_MAX_TRACK;
	localparam int REGION     = DEF_DRIVE_REGION_BYTES;

	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] byte_out;
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic              done;
		logic              err;
		logic              req;
		logic              outm;
	} drive_reply_t;

	drive_reply_t pending_replies[$];

	// predicted drive state
	logic [CMD_W-1:0]  cmd_q;
	logic [PH_W-1:0]   phase_q;
	logic              drive_q;
	int                index_q;
	logic [4:0]        sector_q;
	logic [6:0]        track_q;
	logic [BYTE_W-1:0] sector_data [BUF_BYTES];
	logic              done_q, err_q, req_q, outm_q;
	logic [BYTE_W-1:0] status_q, errreg_q;
	int                reported;

	function automatic void end_command();
		done_q  = 1'b1;
		outm_q  = 1'b0;
		cmd_q   = CMD_NONE;
		phase_q = PH_IDLE;
		index_q = 0;
	endfunction

	function automatic drive_reply_t predict_reply(input logic act, input logic [BYTE_W-1:0] d);
		drive_reply_t r;
		logic         fresh;
		int unsigned  a;
		r     = '0;
		fresh = 1'b0;
		if (act) begin
			r.byte_valid = 1'b1;
			r.byte_out   = INIT_BYTE;
			end_command();
		end else begin
			if (cmd_q == CMD_NONE) begin
				done_q  = 1'b0;
				err_q   = 1'b0;
				drive_q = d[4];
				cmd_q   = {1'b0, d[3:1]};
				phase_q = PH_IDLE;
				fresh   = 1'b1;
			end
			case (cmd_q)
				CMD_FILL: begin
					if (fresh || phase_q != PH_FILL) begin
						phase_q = PH_FILL;
						req_q   = 1'b1;
						index_q = 0;
					end else begin
						sector_data[index_q] = d;
						index_q++;
						if (index_q >= BUF_BYTES) begin
							req_q = 1'b0;
							end_command();
						end else begin
							req_q = 1'b1;
						end
					end
				end
				CMD_EMPTY: begin
					if (fresh || phase_q != PH_EMPTY) begin
						phase_q      = PH_EMPTY;
						outm_q       = 1'b1;
						r.byte_valid = 1'b1;
						r.byte_out   = sector_data[0];
						index_q      = 1;
						req_q        = 1'b1;
					end else if (index_q < BUF_BYTES) begin
						r.byte_valid = 1'b1;
						r.byte_out   = sector_data[index_q];
						index_q++;
						req_q = 1'b1;
					end else begin
						req_q = 1'b0;
						end_command();
					end
				end
				CMD_WRITE, CMD_READ, CMD_WRDEL: begin
					if (fresh || (phase_q != PH_SECTOR && phase_q != PH_TRACK)) begin
						phase_q = PH_SECTOR;
						req_q   = 1'b1;
					end else if (phase_q == PH_SECTOR) begin
						req_q = 1'b0;
						if (d < 1 || d > SPT) begin
							err_q = 1'b1;
							end_command();
						end else begin
							sector_q = 5'(d - 1);
							phase_q  = PH_TRACK;
							req_q    = 1'b1;
						end
					end else begin
						req_q = 1'b0;
						if (d > LAST_TRACK) begin
							err_q = 1'b1;
							end_command();
						end else begin
							track_q = d[6:0];
							a = (track_q * SPT + sector_q) * BUF_BYTES + drive_q * REGION;
							r.addr = a[ADDR_W-1:0];
							r.op   = (cmd_q == CMD_READ) ? OP_READ : OP_WRITE;
							end_command();
						end
					end
				end
				CMD_STATUS: begin
					r.byte_valid = 1'b1;
					r.byte_out   = status_q;
					end_command();
				end
				CMD_ERRREG: begin
					r.byte_valid = 1'b1;
					r.byte_out   = errreg_q;
					end_command();
				end
				default: end_command();
			endcase
		end
		r.done = done_q;
		r.err  = err_q;
		r.req  = req_q;
		r.outm = outm_q;
		return r;
	endfunction

	task automatic flag_reply(input string what, input drive_reply_t want, input drive_reply_t seen);
		mismatches++;
		if (reported < 10) begin
			reported++;
			$display("%0t %s: expected bv=%0d byte=%02h op=%0d addr=%05h done=%0d err=%0d req=%0d out=%0d",
				$time, what, want.byte_valid, want.byte_out, want.op, want.addr,
				want.done, want.err, want.req, want.outm);
			$display("%0t %s: actual   bv=%0d byte=%02h op=%0d addr=%05h done=%0d err=%0d req=%0d out=%0d",
				$time, what, seen.byte_valid, seen.byte_out, seen.op, seen.addr,
				seen.done, seen.err, seen.req, seen.outm);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		drive_reply_t seen, want;
		if (!arst_n) begin
			pending_replies.delete();
			cmd_q    = CMD_NONE;
			phase_q  = PH_IDLE;
			drive_q  = 1'b0;
			index_q  = 0;
			sector_q = '0;
			track_q  = '0;
			for (int i = 0; i < BUF_BYTES; i++)
				sector_data[i] = '0;
			done_q   = 1'b1;
			err_q    = 1'b0;
			req_q    = 1'b0;
			outm_q   = 1'b0;
			status_q = STATUS_RESET;
			errreg_q = ERROR_RESET;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_STATUS)
					status_q = cfg_data;
				else
					errreg_q = cfg_data;
			end
			if (out_valid && out_ready) begin
				seen = {byte_valid, byte_out, storage_op, storage_address,
					done_level, error_level, request_level, output_mode};
				if (pending_replies.size() == 0) begin
					flag_reply("unexpected result", '0, seen);
				end else begin
					want = pending_replies.pop_front();
					if (seen.byte_valid !== want.byte_valid || seen.byte_out !== want.byte_out ||
						seen.op !== want.op || seen.addr !== want.addr ||
						seen.done !== want.done || seen.err !== want.err ||
						seen.req !== want.req || seen.outm !== want.outm)
						flag_reply("mismatch", want, seen);
				end
			end
			// a result always lags its input through the stage and output registers, so popping first is safe
			if (in_valid && in_ready)
				pending_replies.push_back(predict_reply(action, data_in));
			outstanding = pending_replies.size();
		end
	end

endmodule

@@ tb/sv/floppy_drive_command_interface_test.sv @@
module floppy_drive_command_interface_test;
	import fdci_pkg::*;

	localparam int SPT        = DEF_SECTORS_PER_TRACK;
	localparam int LAST_TRACK = DEF_MAX_TRACK;
	localparam int BUF_BYTES  = DEF_BUFFER_BYTES;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              action    = 1'b0;
	logic [BYTE_W-1:0] data_in   = '0;
	logic              cfg_we    = 1'b0;
	logic              cfg_index = CFG_STATUS;
	logic [BYTE_W-1:0] cfg_data  = '0;
	logic              out_ready = 1'b0;
	logic              in_ready, out_valid;
	logic              byte_valid, done_level, error_level, request_level, output_mode;
	logic [BYTE_W-1:0] byte_out;
	logic [OP_W-1:0]   storage_op;
	logic [ADDR_W-1:0] storage_address;

	int mismatches, outstanding;
	int sent_items   = 0;
	int send_idle    = 0;
	int recv_idle    = 0;
	bit hold_request = 1'b0;

	floppy_drive_command_interface dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .data_in(data_in),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.byte_valid(byte_valid), .byte_out(byte_out), .storage_op(storage_op),
		.storage_address(storage_address), .done_level(done_level),
		.error_level(error_level), .request_level(request_level), .output_mode(output_mode)
	);

	floppy_drive_command_interface_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .data_in(data_in),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.byte_valid(byte_valid), .byte_out(byte_out), .storage_op(storage_op),
		.storage_address(storage_address), .done_level(done_level),
		.error_level(error_level), .request_level(request_level), .output_mode(output_mode),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("FAILURE");
		$finish;
	end

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready = 1'b0;
				repeat (300) @(negedge clk);
			end
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic logic [BYTE_W-1:0] command_byte(input logic drive,
		input logic [CMD_W-1:0] cmd);
		logic [BYTE_W-1:0] b;
		b      = 8'($urandom);
		b[4]   = drive;
		b[3:1] = cmd[2:0];
		return b;
	endfunction

	task automatic offer(input logic act, input logic [BYTE_W-1:0] d);
		@(negedge clk);
		if ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			action   = 1'($urandom);
			data_in  = 8'($urandom);
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid = 1'b1;
		action   = act;
		data_in  = d;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic sector_seq(input logic [CMD_W-1:0] cmd, input logic drive,
		input logic [BYTE_W-1:0] sec, input logic [BYTE_W-1:0] trk);
		offer(1'b0, command_byte(drive, cmd));
		offer(1'b0, sec);
		if (sec >= 1 && sec <= SPT)
			offer(1'b0, trk);
	endtask

	task automatic run_random(input int target);
		int                pick, n;
		logic              abort;
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] sec, trk;
		while (sent_items < target) begin
			pick  = $urandom_range(99);
			abort = ($urandom_range(9) == 0);
			if (pick < 10) begin
				offer(1'b0, command_byte(1'($urandom), CMD_FILL));
				n = abort ? $urandom_range(BUF_BYTES - 1) : BUF_BYTES;
				repeat (n) offer(1'b0, 8'($urandom));
				if (abort)
					offer(1'b1, 8'($urandom));
			end else if (pick < 20) begin
				offer(1'b0, command_byte(1'($urandom), CMD_EMPTY));
				n = abort ? $urandom_range(BUF_BYTES - 1) : BUF_BYTES;
				repeat (n) offer(1'b0, 8'($urandom));
				// full run has closed it: this pulse starts a command; init aborts
				offer(abort, 8'($urandom));
			end else if (pick < 65) begin
				case ($urandom_range(2))
					0: cmd = CMD_WRITE;
					1: cmd = CMD_READ;
					default: cmd = CMD_WRDEL;
				endcase
				if ($urandom_range(99) < 85)
					sec = 8'($urandom_range(SPT, 1));
				else
					sec = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, SPT + 1));
				if ($urandom_range(99) < 85)
					trk = 8'($urandom_range(LAST_TRACK));
				else
					trk = 8'($urandom_range(255, LAST_TRACK + 1));
				if ($urandom_range(19) == 0) begin
					offer(1'b0, command_byte(1'($urandom), cmd));
					offer(1'b1, 8'($urandom));
				end else begin
					sector_seq(cmd, 1'($urandom), sec, trk);
				end
			end else if (pick < 85) begin
				case ($urandom_range(2))
					0: cmd = CMD_UNUSED;
					1: cmd = CMD_STATUS;
					default: cmd = CMD_ERRREG;
				endcase
				offer(1'b0, command_byte(1'($urandom), cmd));
			end else begin
				// noise, then an init to get back to a known command state
				offer(1'($urandom), 8'($urandom));
				offer(1'b1, 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_idle = 24;
		recv_idle = 82;

		// directed: reset register values, range edges, aborted transfers
		offer(1'b0, command_byte(1'b0, CMD_STATUS));
		offer(1'b0, command_byte(1'b1, CMD_ERRREG));
		offer(1'b0, command_byte(1'b0, CMD_UNUSED));
		sector_seq(CMD_WRITE, 1'b0, 8'd1, 8'd0);
		sector_seq(CMD_READ, 1'b1, 8'(SPT), 8'(LAST_TRACK));
		sector_seq(CMD_WRDEL, 1'b0, 8'd0, 8'd0);
		sector_seq(CMD_WRITE, 1'b1, 8'(SPT + 1), 8'd0);
		sector_seq(CMD_READ, 1'b0, 8'd5, 8'(LAST_TRACK + 1));
		sector_seq(CMD_READ, 1'b1, 8'd1, 8'hFF);
		offer(1'b0, command_byte(1'b1, CMD_FILL));
		offer(1'b0, 8'hFF);
		offer(1'b0, 8'h00);
		offer(1'b1, 8'h00);
		offer(1'b0, command_byte(1'b0, CMD_EMPTY));
		offer(1'b1, 8'hFF);
		drain();

		write_reg(CFG_STATUS, 8'h00);
		write_reg(CFG_ERROR, 8'hFF);
		run_random(sent_items + 500);
		drain();

		send_idle = 82;
		recv_idle = 24;
		write_reg(CFG_STATUS, 8'hFF);
		write_reg(CFG_ERROR, 8'h00);
		run_random(sent_items + 500);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_STATUS, 8'($urandom));
		write_reg(CFG_ERROR, 8'($urandom));
		hold_request = 1'b1;
		run_random(sent_items + 500);
		drain();
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
